// File: rtl/idft_pkg.sv
// Shared types, constants and helpers for the ID frequency table.
`timescale 1ns / 1ps

package idft_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ID_W          = 16;
  localparam int CNT_W         = 32;

  typedef enum logic [2:0] {
    OP_PACKET       = 3'd0,
    OP_CLEAR_WINDOW = 3'd1,
    OP_BEGIN_SCAN   = 3'd2,
    OP_END_SCAN     = 3'd3,
    OP_READ         = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]      operation;
    logic [ID_W-1:0] app_id;
    logic            table_select;
    logic [2:0]      entry_index;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  entry_id;
    logic [CNT_W-1:0] entry_count;
    logic             scan_on;
    logic [CNT_W-1:0] scan_reply_total;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic            tally;
    logic            clear;
    logic [ID_W-1:0] id;
  } tbl_cmd_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_MATCH,
    T_UPDATE
  } tbl_state_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } ctl_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/id_frequency_table.sv
// Top level of the ID frequency table: command decode, scan state and result register.
//
//   channel  ports                          transfer
//   input    start, busy, in_item           start high and busy low at clk edge
//   result   out_strobe, out_item           one cycle, out_strobe high
//
// A packet is held while its tables walk: the window table, and the scan table while a
// scan is on, walks its entries at most once through one compare unit, then writes
// back. Every other operation gives its result in the cycle after acceptance.
// Synchronous active-low reset clears both tables, the scan flag and the reply counter.
// The receiver cannot stall; a new transaction is taken while the last result is shown.
`timescale 1ns / 1ps

module id_frequency_table import idft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  ctl_state_t       state_r, state_nxt;
  logic             scan_r, scan_nxt;
  logic [CNT_W-1:0] replies_r, replies_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_r, out_nxt;

  logic             accept;
  logic             emit;
  logic [ID_W-1:0]  ent_id;
  logic [CNT_W-1:0] ent_cnt;
  tbl_cmd_t         win_cmd, scn_cmd;
  entry_t           win_entry, scn_entry;
  logic             win_busy, scn_busy;
  logic [IDX_W-1:0] rd_idx;
  logic             idx_ok;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;
  assign rd_idx     = IDX_W'(in_item.entry_index);
  assign idx_ok     = (32'(in_item.entry_index) < TABLE_ENTRIES);

  always_comb begin
    win_cmd.tally = accept && (in_item.operation == OP_PACKET);
    win_cmd.clear = accept && (in_item.operation == OP_CLEAR_WINDOW);
    win_cmd.id    = in_item.app_id;
    scn_cmd.tally = accept && (in_item.operation == OP_PACKET) && scan_r;
    scn_cmd.clear = accept && (in_item.operation == OP_BEGIN_SCAN);
    scn_cmd.id    = in_item.app_id;
  end

  idft_table u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (win_cmd),
    .rd_idx   (rd_idx),
    .rd_entry (win_entry),
    .busy     (win_busy)
  );

  idft_table u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (scn_cmd),
    .rd_idx   (rd_idx),
    .rd_entry (scn_entry),
    .busy     (scn_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    replies_nxt    = replies_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    emit           = 1'b0;
    ent_id         = '0;
    ent_cnt        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.operation)
            OP_PACKET: begin
              if (scan_r) begin
                replies_nxt = sat_inc(replies_r);
              end
              state_nxt = S_WALK;
            end
            OP_BEGIN_SCAN: begin
              scan_nxt    = 1'b1;
              replies_nxt = '0;
              emit        = 1'b1;
            end
            OP_END_SCAN: begin
              scan_nxt = 1'b0;
              emit     = 1'b1;
            end
            OP_READ: begin
              if (idx_ok) begin
                ent_id  = in_item.table_select ? scn_entry.id : win_entry.id;
                ent_cnt = in_item.table_select ? scn_entry.count : win_entry.count;
              end
              emit = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        if (!win_busy && !scn_busy) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (emit) begin
      out_strobe_nxt = 1'b1;
      out_nxt        = '{entry_id: ent_id, entry_count: ent_cnt,
                         scan_on: scan_nxt, scan_reply_total: replies_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_r       <= 1'b0;
      replies_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      replies_r    <= replies_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: rtl/idft_table.sv
// One ID table with its match-and-minimum walk sequencer.
`timescale 1ns / 1ps

module idft_table import idft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_entry,
  output logic             busy
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [ID_W-1:0]  ids_r  [TABLE_ENTRIES];
  logic [CNT_W-1:0] cnts_r [TABLE_ENTRIES];

  tbl_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] low_idx_r, low_idx_nxt;
  logic [CNT_W-1:0] low_cnt_r, low_cnt_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;

  logic [IDX_W-1:0] addr;
  logic [ID_W-1:0]  cur_id;
  logic [CNT_W-1:0] cur_cnt;
  logic             wr_en;
  logic             wr_id_en;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] wr_cnt;

  assign addr     = (state_r == T_IDLE) ? rd_idx : idx_r;
  assign cur_id   = ids_r[addr];
  assign cur_cnt  = cnts_r[addr];
  assign rd_entry = '{id: cur_id, count: cur_cnt};
  assign busy     = (state_r != T_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    low_idx_nxt = low_idx_r;
    low_cnt_nxt = low_cnt_r;
    id_nxt      = id_r;
    wr_en       = 1'b0;
    wr_id_en    = 1'b0;
    wr_idx      = idx_r;
    wr_cnt      = cur_cnt;
    unique case (state_r)
      T_IDLE: begin
        if (cmd.tally) begin
          id_nxt    = cmd.id;
          idx_nxt   = '0;
          state_nxt = T_MATCH;
        end
      end
      T_MATCH: begin
        if ((cur_cnt != '0) && (cur_id == id_r)) begin
          wr_en     = 1'b1;
          wr_cnt    = sat_inc(cur_cnt);
          state_nxt = T_IDLE;
        end else if (cur_cnt == '0) begin
          wr_en     = 1'b1;
          wr_id_en  = 1'b1;
          wr_cnt    = CNT_W'(1);
          state_nxt = T_IDLE;
        end else begin
          if ((idx_r == '0) || (cur_cnt < low_cnt_r)) begin
            low_idx_nxt = idx_r;
            low_cnt_nxt = cur_cnt;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = T_UPDATE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      T_UPDATE: begin
        wr_en  = 1'b1;
        wr_idx = low_idx_r;
        if (low_cnt_r <= CNT_W'(1)) begin
          wr_id_en = 1'b1;
          wr_cnt   = CNT_W'(1);
        end else begin
          wr_cnt = sat_inc(low_cnt_r);
        end
        state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    low_idx_r <= low_idx_nxt;
    low_cnt_r <= low_cnt_nxt;
    id_r      <= id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ids_r[i]  <= '0;
        cnts_r[i] <= '0;
      end
    end else if (wr_en) begin
      cnts_r[wr_idx] <= wr_cnt;
      if (wr_id_en) begin
        ids_r[wr_idx] <= id_r;
      end
    end
  end

endmodule
